[sv/efc_pkg.sv]
package efc_pkg;

    localparam int HEADER_BYTES = 42;

    localparam logic [1:0] CLASS_ETH2 = 2'd0;
    localparam logic [1:0] CLASS_RAW  = 2'd1;
    localparam logic [1:0] CLASS_SNAP = 2'd2;
    localparam logic [1:0] CLASS_LLC  = 2'd3;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_IPV4 = 2'd1;
    localparam logic [1:0] KIND_IPV6 = 2'd2;
    localparam logic [1:0] KIND_ARP  = 2'd3;

    localparam logic [15:0] MAX_LLC_LENGTH = 16'd1500;
    localparam logic [15:0] ETYPE_IPV4     = 16'd2048;
    localparam logic [15:0] ETYPE_IPV6     = 16'd34525;
    localparam logic [15:0] ETYPE_ARP      = 16'd2054;
    localparam logic [15:0] ARP_REQUEST    = 16'd1;
    localparam logic [7:0]  SSAP_RAW       = 8'd255;
    localparam logic [7:0]  SSAP_SNAP      = 8'd170;
    localparam logic [15:0] MAX_POSITION   = 16'hFFFF;
    localparam logic [16:0] MIN_FRAME      = 17'd60;
    localparam logic [16:0] MIN_WIRE       = 17'd64;
    localparam logic [16:0] FCS_BYTES      = 17'd4;
    localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  frame_class;
        logic [15:0] type_value;
        logic [16:0] wire_length;
        logic [1:0]  layer3_kind;
        logic [7:0]  layer3_code;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic        count_dest;
    } efc_desc_t;

    typedef struct packed {
        efc_desc_t   desc;
        logic [31:0] dest_count;
        logic [31:0] top_address;
        logic [31:0] top_count;
        logic        dropped_new;
    } efc_result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_TOP_READ,
        BK_EMIT
    } efc_back_state_t;

endpackage

[sv/efc_front.sv]
module efc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [7:0]          frame_byte,
    input  logic                frame_end,
    input  logic                track,
    output logic                push,
    output efc_pkg::efc_desc_t  desc
);
    import efc_pkg::*;

    logic [7:0]  hdr_reg [HEADER_BYTES];
    logic [7:0]  hv [HEADER_BYTES];
    logic [15:0] pos_reg;
    logic [15:0] len;
    logic [15:0] etype;
    logic [16:0] len17;
    logic        accept;

    assign accept = in_valid && !in_stall;
    assign push   = accept && frame_end;
    assign len    = (pos_reg != MAX_POSITION) ? pos_reg + 16'd1 : MAX_POSITION;
    assign len17  = {1'b0, len};

    always_comb
    begin
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            hv[i] = (pos_reg == 16'(i)) ? frame_byte : hdr_reg[i];
        end
    end

    assign etype = {hv[12], hv[13]};

    always_comb
    begin
        desc             = '0;
        desc.wire_length = (len17 >= MIN_FRAME) ? len17 + FCS_BYTES : MIN_WIRE;
        if (etype > MAX_LLC_LENGTH)
        begin
            desc.frame_class = CLASS_ETH2;
            desc.type_value  = etype;
            if (etype == ETYPE_IPV4)
            begin
                desc.layer3_kind = KIND_IPV4;
                desc.layer3_code = hv[23];
                desc.source_ip   = {hv[26], hv[27], hv[28], hv[29]};
                desc.dest_ip     = {hv[30], hv[31], hv[32], hv[33]};
                desc.count_dest  = track;
            end
            else if (etype == ETYPE_IPV6)
            begin
                desc.layer3_kind = KIND_IPV6;
                desc.layer3_code = hv[20];
            end
            else if (etype == ETYPE_ARP)
            begin
                desc.layer3_kind = KIND_ARP;
                desc.layer3_code = ({hv[20], hv[21]} == ARP_REQUEST) ? 8'd1 : 8'd0;
                desc.source_ip   = {hv[28], hv[29], hv[30], hv[31]};
                desc.dest_ip     = {hv[38], hv[39], hv[40], hv[41]};
            end
        end
        else if (hv[15] == SSAP_RAW)
        begin
            desc.frame_class = CLASS_RAW;
            desc.type_value  = {8'd0, SSAP_RAW};
        end
        else if (hv[15] == SSAP_SNAP)
        begin
            desc.frame_class = CLASS_SNAP;
            desc.type_value  = {hv[20], hv[21]};
        end
        else
        begin
            desc.frame_class = CLASS_LLC;
            desc.type_value  = {8'd0, hv[15]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                pos_reg <= '0;
                for (int i = 0; i < HEADER_BYTES; i++)
                begin
                    hdr_reg[i] <= '0;
                end
            end
            else
            begin
                pos_reg <= len;
                for (int i = 0; i < HEADER_BYTES; i++)
                begin
                    if (pos_reg == 16'(i))
                    begin
                        hdr_reg[i] <= frame_byte;
                    end
                end
            end
        end
    end

endmodule

[sv/efc_queue.sv]
module efc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  efc_pkg::efc_desc_t  push_data,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output efc_pkg::efc_desc_t  pop_data
);
    import efc_pkg::*;

    efc_desc_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[sv/efc_back.sv]
module efc_back #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  efc_pkg::efc_desc_t    q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output efc_pkg::efc_result_t  result
);
    import efc_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    logic [31:0] addr_mem [TABLE_ENTRIES];
    logic [31:0] cnt_mem  [TABLE_ENTRIES];
    logic [31:0] rd_addr_reg;
    logic [31:0] rd_cnt_reg;

    efc_back_state_t state_reg, state_next;
    efc_desc_t       work_reg, work_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   used_reg, used_next;
    logic [CW-1:0]   best_idx_reg, best_idx_next;
    logic [31:0]     best_cnt_reg, best_cnt_next;
    logic [31:0]     dcount_reg, dcount_next;
    logic            drop_reg, drop_next;
    efc_result_t     out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic            rd_en;
    logic [IW-1:0]   rd_idx;
    logic            we_addr;
    logic            we_cnt;
    logic [IW-1:0]   wr_idx;
    logic [31:0]     wr_cnt;
    logic [31:0]     bumped;
    logic            load_out;

    assign out_valid = out_valid_reg;
    assign result    = out_reg;
    assign bumped    = (rd_cnt_reg != COUNT_MAX) ? rd_cnt_reg + 32'd1 : COUNT_MAX;
    assign load_out  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (we_addr)
        begin
            addr_mem[wr_idx] <= work_reg.dest_ip;
        end
        if (we_cnt)
        begin
            cnt_mem[wr_idx] <= wr_cnt;
        end
        if (rd_en)
        begin
            rd_addr_reg <= addr_mem[rd_idx];
            rd_cnt_reg  <= cnt_mem[rd_idx];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        best_idx_next  = best_idx_reg;
        best_cnt_next  = best_cnt_reg;
        dcount_next    = dcount_reg;
        drop_next      = drop_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_idx         = idx_reg[IW-1:0];
        we_addr        = 1'b0;
        we_cnt         = 1'b0;
        wr_idx         = idx_reg[IW-1:0];
        wr_cnt         = bumped;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    work_next   = q_data;
                    idx_next    = '0;
                    dcount_next = '0;
                    drop_next   = 1'b0;
                    state_next  = q_data.count_dest ? BK_READ : BK_TOP_READ;
                end
            end
            BK_READ:
            begin
                if (idx_reg == used_reg)
                begin
                    if (used_reg < FULL_COUNT)
                    begin
                        we_addr     = 1'b1;
                        we_cnt      = 1'b1;
                        wr_idx      = used_reg[IW-1:0];
                        wr_cnt      = 32'd1;
                        dcount_next = 32'd1;
                        used_next   = used_reg + CW'(1);
                        if ((best_cnt_reg < 32'd1) ||
                            (best_cnt_reg == 32'd1 && used_reg < best_idx_reg))
                        begin
                            best_cnt_next = 32'd1;
                            best_idx_next = used_reg;
                        end
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    state_next = BK_TOP_READ;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                if (rd_addr_reg == work_reg.dest_ip)
                begin
                    we_cnt      = 1'b1;
                    dcount_next = bumped;
                    if ((bumped > best_cnt_reg) ||
                        (bumped == best_cnt_reg && idx_reg < best_idx_reg))
                    begin
                        best_cnt_next = bumped;
                        best_idx_next = idx_reg;
                    end
                    state_next = BK_TOP_READ;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = BK_READ;
                end
            end
            BK_TOP_READ:
            begin
                rd_en      = 1'b1;
                rd_idx     = best_idx_reg[IW-1:0];
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (load_out)
                begin
                    out_next.desc        = work_reg;
                    out_next.dest_count  = dcount_reg;
                    out_next.dropped_new = drop_reg;
                    out_next.top_address = (used_reg != '0) ? rd_addr_reg : 32'd0;
                    out_next.top_count   = (used_reg != '0) ? best_cnt_reg : 32'd0;
                    out_valid_next       = 1'b1;
                    state_next           = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        dcount_reg <= dcount_next;
        drop_reg   <= drop_next;
        idx_reg    <= idx_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            used_reg      <= '0;
            best_idx_reg  <= '0;
            best_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            best_idx_reg  <= best_idx_next;
            best_cnt_reg  <= best_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/ethernet_frame_classifier_dest_counter.sv]
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  frame_byte, frame_end
// result    out        out_valid/out_stall  frame_class ... dropped_new
// config    in         cfg_valid/cfg_ready  track_destinations
//
// Bytes are taken one per cycle while in_stall is low; the frame's last beat enters a two-entry queue.
// An IPv4 frame with tracking on is searched entry by entry (read, then check), and
// its address is added when new and the table has room; every frame then has its top
// entry read and is emitted by the table unit, which has one memory port.
// The input stalls only while the queue holds two frames.
// Reset clears the header capture, the table fill count and the top entry.
module ethernet_frame_classifier_dest_counter #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  frame_class,
    output logic [15:0] type_value,
    output logic [16:0] wire_length,
    output logic [1:0]  layer3_kind,
    output logic [7:0]  layer3_code,
    output logic [31:0] source_ip,
    output logic [31:0] dest_ip,
    output logic [31:0] dest_count,
    output logic [31:0] top_address,
    output logic [31:0] top_count,
    output logic        dropped_new,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        track_destinations
);
    import efc_pkg::*;

    logic        track_reg;
    logic        push;
    logic        full;
    logic        q_valid;
    logic        q_pop;
    efc_desc_t   desc;
    efc_desc_t   q_data;
    efc_result_t result;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            track_reg <= track_destinations;
        end
    end

    efc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .track      (track_reg),
        .push       (push),
        .desc       (desc)
    );

    efc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (desc),
        .pop       (q_pop),
        .full      (full),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    efc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign frame_class = result.desc.frame_class;
    assign type_value  = result.desc.type_value;
    assign wire_length = result.desc.wire_length;
    assign layer3_kind = result.desc.layer3_kind;
    assign layer3_code = result.desc.layer3_code;
    assign source_ip   = result.desc.source_ip;
    assign dest_ip     = result.desc.dest_ip;
    assign dest_count  = result.dest_count;
    assign top_address = result.top_address;
    assign top_count   = result.top_count;
    assign dropped_new = result.dropped_new;

endmodule
